>>> rtl/core/buddy_block_allocator_top_macros.svh
`ifndef BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define BUDDY_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// clocked assertion, off while reset is held
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// same with a fixed message
`define BBA_CHECK(lbl, prop) \
  `BBA_ASSERT(lbl, prop, "bba port check failed")

`endif

>>> rtl/core/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

  localparam int unsigned MaxOrderDef = 10;
  localparam logic [3:0]  MaxOrderRst = 4'd10;
  localparam int unsigned OrdW        = 5;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC   = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_FREED   = 2'd2;
  localparam logic [1:0] ST_REJECT  = 2'd3;

  typedef struct packed {
    logic        command;
    logic [11:0] block_count;
    logic [9:0]  block_offset;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  result_offset;
    logic [10:0] freed_count;
  } out_item_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LOAD, OP_NOSPACE, OP_REJECT, OP_ORD_INC,
    OP_SPLIT_RD, OP_SPLIT_A, OP_SPLIT_B, OP_POP_RD, OP_POP_FIN,
    OP_FSTART, OP_WALK_HIT, OP_WALK_MISS, OP_WALK_NEXT,
    OP_UNLINK_A, OP_UNLINK_B, OP_PUSH, OP_OUT
  } op_t;

  typedef struct packed {
    op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic is_free;
    logic big_alloc;
    logic big_free;
    logic head_v;
    logic ord_eq_tgt;
    logic ord_eq_lim;
    logic ord_eq_top;
    logic walk_end;
    logic hit;
    logic out_busy;
  } dp_stat_t;

  // smallest order whose size covers the count, zero and one give order zero
  function automatic logic [OrdW-1:0] order_of(input logic [11:0] count);
    logic [11:0]     cm1;
    logic [OrdW-1:0] o;
    cm1 = count - 12'd1;
    o   = '0;
    if (count > 12'd1) begin
      for (int i = 0; i < 12; i++) begin
        if (cm1[i]) begin
          o = OrdW'(i + 1);
        end
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/bba_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire bba_pkg::dp_stat_t stat,
  output bba_pkg::dp_cmd_t       cmd
);
  import bba_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SEARCH, S_SPLIT1, S_SPLIT2, S_POP,
    S_FCHK, S_WALK, S_WNEXT, S_UNL1, S_UNL2, S_FIN
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat.is_free) begin
          if (stat.big_alloc) begin
            cmd.op    = OP_NOSPACE;
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SEARCH;
          end
        end else if (stat.big_free) begin
          cmd.op    = OP_REJECT;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_FCHK;
        end
      end
      S_SEARCH: begin
        if (stat.head_v) begin
          if (stat.ord_eq_tgt) begin
            cmd.op    = OP_POP_RD;
            state_nxt = S_POP;
          end else begin
            cmd.op    = OP_SPLIT_RD;
            state_nxt = S_SPLIT1;
          end
        end else if (stat.ord_eq_lim) begin
          cmd.op    = OP_NOSPACE;
          state_nxt = S_FIN;
        end else begin
          cmd.op = OP_ORD_INC;
        end
      end
      S_SPLIT1: begin
        cmd.op    = OP_SPLIT_A;
        state_nxt = S_SPLIT2;
      end
      S_SPLIT2: begin
        cmd.op    = OP_SPLIT_B;
        state_nxt = S_SEARCH;
      end
      S_POP: begin
        cmd.op    = OP_POP_FIN;
        state_nxt = S_FIN;
      end
      S_FCHK: begin
        if (stat.ord_eq_top) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_FIN;
        end else begin
          cmd.op    = OP_FSTART;
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.walk_end) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_FIN;
        end else if (stat.hit) begin
          cmd.op    = OP_WALK_HIT;
          state_nxt = S_UNL1;
        end else begin
          cmd.op    = OP_WALK_MISS;
          state_nxt = S_WNEXT;
        end
      end
      S_WNEXT: begin
        cmd.op    = OP_WALK_NEXT;
        state_nxt = S_WALK;
      end
      S_UNL1: begin
        cmd.op    = OP_UNLINK_A;
        state_nxt = S_UNL2;
      end
      S_UNL2: begin
        cmd.op    = OP_UNLINK_B;
        state_nxt = S_FCHK;
      end
      S_FIN: begin
        if (!stat.out_busy) begin
          cmd.op    = OP_OUT;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/bba_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_dp #(
  parameter int unsigned MaxOrder = bba_pkg::MaxOrderDef
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic [3:0]        cfg_wdata,
  input  wire bba_pkg::in_item_t in_item,
  input  wire bba_pkg::dp_cmd_t  cmd,
  output bba_pkg::dp_stat_t      stat,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output bba_pkg::out_item_t     out_item
);
  import bba_pkg::*;

  localparam int unsigned AW   = MaxOrder;
  localparam int unsigned LW   = MaxOrder + 1;
  localparam int unsigned NBLK = 1 << MaxOrder;
  localparam int unsigned HD   = MaxOrder + 1;
  localparam int unsigned HIW  = (HD > 1) ? $clog2(HD) : 1;

  // free list heads, valid bit on top
  logic [LW-1:0] head_r [HD];
  // next links, one per block
  logic [LW-1:0] mem [NBLK];

  logic [3:0]      max_r;
  logic            z0_r;
  logic [LW-1:0]   rdata_r;
  logic            rd_zero_r;
  logic            cmd_r;
  logic [OrdW-1:0] tgt_r, ord_r;
  logic [AW-1:0]   addr_r, buddy_r, prev_r, left_r, right_r;
  logic [LW-1:0]   cur_r;
  logic            has_prev_r;
  logic [LW-1:0]   steps_r;
  logic [1:0]      res_status_r;
  logic [9:0]      res_ofs_r;
  logic [10:0]     res_freed_r;
  out_item_t       out_r;
  logic            out_valid_r;

  logic [OrdW-1:0] lim, init_lim;
  logic [HIW-1:0]  ord_idx, init_idx;
  logic [LW-1:0]   head_sel, link_rd;
  logic [AW-1:0]   head_ofs, cur_ofs, right;
  logic [3:0]      init_max;
  logic [31:0]     one_sh;

  logic            mem_we, mem_re, head_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [LW-1:0]   mem_wd, head_wd;

  assign lim = (OrdW'(max_r) > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : OrdW'(max_r);
  assign init_max = rst_n ? cfg_wdata : MaxOrderRst;
  assign init_lim = (OrdW'(init_max) > OrdW'(MaxOrder)) ? OrdW'(MaxOrder) : OrdW'(init_max);
  assign init_idx = init_lim[HIW-1:0];

  assign ord_idx  = ord_r[HIW-1:0];
  assign head_sel = head_r[ord_idx];
  assign head_ofs = head_sel[AW-1:0];
  assign cur_ofs  = cur_r[AW-1:0];
  // entry zero reads null until written after reinit
  assign link_rd  = rd_zero_r ? '0 : rdata_r;
  assign right    = left_r + (AW'(1) << (ord_r - OrdW'(1)));
  assign one_sh   = 32'd1 << ord_r;

  assign stat.is_free    = cmd_r;
  assign stat.big_alloc  = tgt_r > lim;
  assign stat.big_free   = tgt_r > OrdW'(MaxOrder);
  assign stat.head_v     = head_sel[AW];
  assign stat.ord_eq_tgt = ord_r == tgt_r;
  assign stat.ord_eq_lim = ord_r == lim;
  assign stat.ord_eq_top = ord_r == OrdW'(MaxOrder);
  assign stat.walk_end   = (steps_r == LW'(NBLK)) || !cur_r[AW];
  assign stat.hit        = cur_ofs == buddy_r;
  assign stat.out_busy   = out_valid_r && !out_ready;

  always_comb begin
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    head_we = 1'b0;
    mem_wa  = '0;
    mem_ra  = '0;
    mem_wd  = '0;
    head_wd = '0;
    case (cmd.op)
      OP_SPLIT_RD: begin
        mem_re = 1'b1;
        mem_ra = head_ofs;
      end
      OP_SPLIT_A: begin
        head_we = 1'b1;
        head_wd = link_rd;
        mem_we  = 1'b1;
        mem_wa  = left_r;
        mem_wd  = {1'b1, right};
      end
      OP_SPLIT_B: begin
        mem_we  = 1'b1;
        mem_wa  = right_r;
        mem_wd  = head_sel;
        head_we = 1'b1;
        head_wd = {1'b1, left_r};
      end
      OP_POP_RD: begin
        mem_re = 1'b1;
        mem_ra = head_ofs;
      end
      OP_POP_FIN: begin
        head_we = 1'b1;
        head_wd = link_rd;
      end
      OP_WALK_HIT, OP_WALK_MISS: begin
        mem_re = 1'b1;
        mem_ra = cur_ofs;
      end
      OP_UNLINK_A: begin
        if (has_prev_r) begin
          mem_we = 1'b1;
          mem_wa = prev_r;
          mem_wd = link_rd;
        end else begin
          head_we = 1'b1;
          head_wd = link_rd;
        end
      end
      OP_UNLINK_B: begin
        mem_we = 1'b1;
        mem_wa = buddy_r;
        mem_wd = '0;
      end
      OP_PUSH: begin
        mem_we  = 1'b1;
        mem_wa  = addr_r;
        mem_wd  = head_sel;
        head_we = 1'b1;
        head_wd = {1'b1, addr_r};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_r   <= mem[mem_ra];
      rd_zero_r <= (mem_ra == '0) && !z0_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      for (int h = 0; h < HD; h++) begin
        head_r[h] <= (HIW'(h) == init_idx) ? {1'b1, AW'(0)} : '0;
      end
      z0_r  <= 1'b0;
      max_r <= init_max;
    end else begin
      if (head_we) begin
        head_r[ord_idx] <= head_wd;
      end
      if (mem_we && (mem_wa == '0)) begin
        z0_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        cmd_r  <= in_item.command;
        tgt_r  <= order_of(in_item.block_count);
        ord_r  <= order_of(in_item.block_count);
        addr_r <= AW'(in_item.block_offset);
      end
      OP_NOSPACE: begin
        res_status_r <= ST_NOSPACE;
        res_ofs_r    <= '0;
        res_freed_r  <= '0;
      end
      OP_REJECT: begin
        res_status_r <= ST_REJECT;
        res_ofs_r    <= '0;
        res_freed_r  <= '0;
      end
      OP_ORD_INC: ord_r <= ord_r + OrdW'(1);
      OP_SPLIT_RD: left_r <= head_ofs;
      OP_SPLIT_A: begin
        right_r <= right;
        ord_r   <= ord_r - OrdW'(1);
      end
      OP_POP_RD: res_ofs_r <= 10'(head_ofs);
      OP_POP_FIN: begin
        res_status_r <= ST_ALLOC;
        res_freed_r  <= '0;
      end
      OP_FSTART: begin
        buddy_r    <= addr_r ^ (AW'(1) << ord_r);
        cur_r      <= head_sel;
        has_prev_r <= 1'b0;
        steps_r    <= '0;
      end
      OP_WALK_MISS: begin
        prev_r     <= cur_ofs;
        has_prev_r <= 1'b1;
        steps_r    <= steps_r + LW'(1);
      end
      OP_WALK_NEXT: cur_r <= link_rd;
      OP_UNLINK_B: begin
        if (addr_r > buddy_r) begin
          addr_r <= buddy_r;
        end
        ord_r <= ord_r + OrdW'(1);
      end
      OP_PUSH: begin
        res_status_r <= ST_FREED;
        res_ofs_r    <= 10'(addr_r);
        res_freed_r  <= one_sh[10:0];
      end
      OP_OUT: begin
        out_r.status        <= res_status_r;
        out_r.result_offset <= res_ofs_r;
        out_r.freed_count   <= res_freed_r;
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

`default_nettype wire

>>> rtl/core/buddy_block_allocator_top.sv
// allocate: search upward past empty orders, then split down to the target order;
//   free: walk the free list for the buddy and merge until no buddy is found or the
//   top order is reached; oversize items skip both; all wait while a result is held
// throughput: one item at a time, set by the single next-link memory port;
//   a new item is taken while a result waits
// reset: synchronous active low, heads reinitialized directly, no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module buddy_block_allocator_top #(
  parameter int unsigned MaxOrder = bba_pkg::MaxOrderDef
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration: max order, rewrite reinitializes free lists
  input  wire logic               cfg_we,
  input  wire logic [3:0]         cfg_wdata,
  // request items
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire bba_pkg::in_item_t  in_item,
  // result items
  output logic                    out_valid,
  input  wire logic               out_ready,
  output bba_pkg::out_item_t      out_item
);
  import bba_pkg::*;

  // command and status between sequencer and datapath
  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: search, split, list walk and merge steps
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // datapath: head registers, next-link memory, result register
  bba_dp #(
    .MaxOrder (MaxOrder)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire

>>> rtl/core/bba_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "buddy_block_allocator_top_macros.svh"

module bba_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire bba_pkg::out_item_t out_item
);
  import bba_pkg::*;

  `BBA_ASSERT(a_one_at_a_time, in_valid && in_ready |=> !in_ready, "second item taken early")
  `BBA_CHECK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item))
  `BBA_ASSERT(a_alloc_no_freed, out_valid && (out_item.status == ST_ALLOC || out_item.status == ST_NOSPACE) |-> out_item.freed_count == 11'd0, "allocate reports freed blocks")
  `BBA_ASSERT(a_fail_zero, out_valid && (out_item.status == ST_REJECT || out_item.status == ST_NOSPACE) |-> out_item.result_offset == 10'd0, "failed item with offset")
  `BBA_CHECK(a_freed_pow2, out_valid && out_item.status == ST_FREED |-> $onehot(out_item.freed_count))

endmodule

bind buddy_block_allocator_top bba_checker u_bba_checker (.*);

`default_nettype wire

>>> sim/buddy_alloc_checker.sv
`timescale 1ns / 1ps

module buddy_alloc_checker #(
  parameter int unsigned MaxOrder = bba_pkg::MaxOrderDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [3:0]         cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  bba_pkg::in_item_t  in_item,
  input  logic               out_valid,
  input  logic               out_ready,
  input  bba_pkg::out_item_t out_item,
  output int                 fail_cnt,
  output int                 pending_cnt
);
  import bba_pkg::*;

  localparam int unsigned NumBlk = 1 << MaxOrder;
  localparam logic [10:0] Live = 11'(NumBlk);

  logic [3:0]  top_order;
  logic [10:0] free_head [0:MaxOrder];
  logic [10:0] blk_link  [0:NumBlk-1];
  out_item_t   want_q[$];

  function automatic int unsigned ceiling_order();
    return (top_order > MaxOrder) ? MaxOrder : top_order;
  endfunction

  function automatic void rebuild_lists();
    for (int i = 0; i <= MaxOrder; i++) free_head[i] = '0;
    for (int i = 0; i < NumBlk; i++) blk_link[i] = '0;
    free_head[ceiling_order()] = Live;
  endfunction

  function automatic bit take_head(int unsigned o, output logic [9:0] ofs);
    if (!free_head[o][10]) return 0;
    ofs = free_head[o][9:0];
    free_head[o] = blk_link[ofs];
    return 1;
  endfunction

  function automatic bit drop_buddy(int unsigned o, logic [9:0] target);
    logic [10:0] cur;
    logic [9:0]  prv;
    bit          has_prv;
    cur = free_head[o];
    prv = '0;
    has_prv = 0;
    for (int s = 0; s < NumBlk && cur[10]; s++) begin
      if (cur[9:0] == target) begin
        if (has_prv) blk_link[prv] = blk_link[target];
        else free_head[o] = blk_link[target];
        blk_link[target] = '0;
        return 1;
      end
      prv = cur[9:0];
      has_prv = 1;
      cur = blk_link[prv];
    end
    return 0;
  endfunction

  function automatic out_item_t serve_request(in_item_t req);
    out_item_t   res;
    int unsigned o, m, i;
    logic [9:0]  left, right, addr, buddy;
    res = '0;
    o = 0;
    while (o < 31 && (1 << o) < req.block_count) o++;
    if (req.command == CMD_ALLOC) begin
      res.status = ST_NOSPACE;
      m = ceiling_order();
      if (o <= m) begin
        i = o;
        while (i <= m && !free_head[i][10]) i++;
        if (i <= m) begin
          while (i > o) begin
            if (take_head(i, left)) begin
              right = left + 10'(1 << (i - 1));
              blk_link[left] = Live | right;
              blk_link[right] = free_head[i-1];
              free_head[i-1] = Live | left;
            end
            i--;
          end
          if (take_head(o, addr)) begin
            res.status = ST_ALLOC;
            res.result_offset = addr;
          end
        end
      end
    end else if (o > MaxOrder) begin
      res.status = ST_REJECT;
    end else begin
      addr = req.block_offset;
      while (o < MaxOrder) begin
        buddy = addr ^ 10'(1 << o);
        if (!drop_buddy(o, buddy)) break;
        if (addr > buddy) addr = buddy;
        o++;
      end
      blk_link[addr] = free_head[o];
      free_head[o] = Live | addr;
      res.status = ST_FREED;
      res.result_offset = addr;
      res.freed_count = 11'(1 << o);
    end
    return res;
  endfunction

  assign pending_cnt = want_q.size();

  always @(posedge clk) begin
    out_item_t w;
    int        errs;
    errs = 0;
    if (!rst_n) begin
      top_order = MaxOrderRst;
      rebuild_lists();
      want_q.delete();
      fail_cnt <= 0;
    end else begin
      if (cfg_we) begin
        top_order = cfg_wdata;
        rebuild_lists();
      end
      if (out_valid && out_ready) begin
        if (want_q.size() == 0) begin
          $error("unexpected result item %p", out_item);
          errs++;
        end else begin
          w = want_q.pop_front();
          if (w.status !== out_item.status) begin
            $error("status exp %0d got %0d", w.status, out_item.status);
            errs++;
          end
          if (w.result_offset !== out_item.result_offset) begin
            $error("result_offset exp %0d got %0d", w.result_offset, out_item.result_offset);
            errs++;
          end
          if (w.freed_count !== out_item.freed_count) begin
            $error("freed_count exp %0d got %0d", w.freed_count, out_item.freed_count);
            errs++;
          end
        end
      end
      if (in_valid && in_ready) want_q.push_back(serve_request(in_item));
      fail_cnt <= fail_cnt + errs;
    end
  end

endmodule

>>> sim/tb_buddy_block_allocator_top.sv
`timescale 1ns / 1ps

module tb_buddy_block_allocator_top;
  import bba_pkg::*;

  typedef struct {
    logic [9:0]  ofs;
    logic [11:0] cnt;
  } region_t;

  logic               clk = 0;
  logic               rst_n = 0;
  logic               cfg_we = 0;
  logic [3:0]         cfg_wdata = '0;
  logic               in_valid = 0;
  logic               in_ready;
  in_item_t           in_item = '0;
  logic               out_valid;
  logic               out_ready = 0;
  out_item_t          out_item;
  int                 fail_cnt;
  int                 pending_cnt;

  // allocations still held, learned from the result channel
  region_t            held_q[$];
  // counts of items sent, in order, so each result can be matched to its size
  logic [11:0]        sent_cnt_q[$];
  bit                 calm = 0;
  int                 idle_cycles = 0;

  always #5 clk = ~clk;

  buddy_block_allocator_top uut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  buddy_alloc_checker chk (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .fail_cnt(fail_cnt), .pending_cnt(pending_cnt)
  );

  // receiver side: ready drops in random bursts, never once calm
  always @(posedge clk) begin
    int unsigned stall_left;
    if (!rst_n) begin
      stall_left = 0;
      out_ready <= 1'b1;
    end else if (calm) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(1, 17);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // remember granted regions so later frees can return them
  always @(posedge clk) begin
    logic [11:0] c;
    int unsigned o;
    if (rst_n && out_valid && out_ready && sent_cnt_q.size() > 0) begin
      c = sent_cnt_q.pop_front();
      if (out_item.status == ST_ALLOC) begin
        o = 0;
        while ((1 << o) < c) o++;
        held_q.push_back('{out_item.result_offset, 12'(1 << o)});
      end
    end
  end

  // watchdog: any long stretch with no item moving is a hang
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= 200000) begin
      $display("[buddy_block_allocator_top] ERROR");
      $finish;
    end
  end

  // one request item; holds valid and payload until in_ready is seen at an edge
  task automatic send_req(logic cmd, logic [11:0] cnt, logic [9:0] ofs);
    in_item_t it;
    it.command = cmd;
    it.block_count = cnt;
    it.block_offset = ofs;
    // sender gaps: valid low for a burst before this item
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= it;
    sent_cnt_q.push_back(cmd == CMD_ALLOC ? cnt : 12'd0);
    do @(posedge clk); while (!in_ready);
  endtask

  // drain, then write max order while the block sits idle
  task automatic set_max_order(logic [3:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    held_q.delete();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // mostly small power-of-two-ish requests, a few big ones
  task automatic random_alloc();
    logic [11:0] c;
    case ($urandom_range(0, 9))
      0:       c = 12'($urandom_range(0, 4095));
      1:       c = 12'($urandom_range(64, 1024));
      default: c = 12'($urandom_range(0, 1 << $urandom_range(0, 4)));
    endcase
    send_req(CMD_ALLOC, c, 10'($urandom));
  endtask

  task automatic random_step();
    int unsigned pick;
    int unsigned idx;
    region_t     r;
    pick = $urandom_range(0, 99);
    if (pick < 50 || (pick < 88 && held_q.size() == 0)) begin
      random_alloc();
    end else if (pick < 88) begin
      // well-formed free of a held region, exact or rounded-down count
      idx = $urandom_range(0, held_q.size() - 1);
      r = held_q[idx];
      held_q.delete(idx);
      send_req(CMD_FREE, (r.cnt > 1 && $urandom_range(0, 3) == 0) ?
               12'(r.cnt / 2 + 1) : r.cnt, r.ofs);
    end else begin
      // noise: arbitrary offsets, double frees, oversize counts
      send_req(CMD_FREE, 12'($urandom_range(0, 4095)), 10'($urandom));
    end
  endtask

  initial begin
    logic [3:0] phase_order [6] = '{4'd0, 4'd3, 4'd15, 4'd5, 4'd1, 4'd10};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: zero count, rounding, no space, oversize frees, merge chain
    send_req(CMD_ALLOC, 12'd0, 10'd0);
    send_req(CMD_ALLOC, 12'd1, 10'd0);
    send_req(CMD_ALLOC, 12'd3, 10'd0);
    send_req(CMD_ALLOC, 12'd1024, 10'd0);
    send_req(CMD_ALLOC, 12'd4095, 10'h3ff);
    send_req(CMD_FREE, 12'd1025, 10'd0);
    send_req(CMD_FREE, 12'd4095, 10'h3ff);
    send_req(CMD_FREE, 12'd1, 10'd0);
    send_req(CMD_FREE, 12'd1, 10'd1);
    send_req(CMD_FREE, 12'd4, 10'd4);
    send_req(CMD_ALLOC, 12'd1024, 10'd0);
    send_req(CMD_FREE, 12'd1024, 10'h3ff);
    send_req(CMD_FREE, 12'd0, 10'h2aa);
    send_req(CMD_FREE, 12'd2048, 10'h155);
    send_req(CMD_ALLOC, 12'd512, 10'd0);
    send_req(CMD_ALLOC, 12'd512, 10'd0);
    send_req(CMD_ALLOC, 12'd1, 10'd0);
    set_max_order(4'd0);
    send_req(CMD_ALLOC, 12'd2, 10'd0);
    send_req(CMD_ALLOC, 12'd1, 10'd0);
    send_req(CMD_ALLOC, 12'd1, 10'd0);
    send_req(CMD_FREE, 12'd1, 10'd0);

    // random phases through several max orders, oversize among them
    foreach (phase_order[p]) begin
      set_max_order(phase_order[p]);
      if (p == 5) calm = 1;
      repeat (300) random_step();
    end

    in_valid <= 1'b0;
    while (pending_cnt != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("[buddy_block_allocator_top] OK");
    end else begin
      $display("[buddy_block_allocator_top] ERROR");
    end
    $finish;
  end

endmodule
